// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for section_run_finder_core
// Clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

// File: sv/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg
// Widths, codes and sizes for the section run finder.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

	localparam int unsigned POOL_SECTIONS = 1024;

	localparam int unsigned OWNER_W  = 9;
	localparam int unsigned NUMBER_W = 24;
	localparam int unsigned LENGTH_W = 11;
	localparam int unsigned MODE_W   = 2;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 11;

	localparam int unsigned IN_FIELDS_W  = OWNER_W + NUMBER_W;
	localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELDS_W = NUMBER_W + LENGTH_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_LARGEST_FREE   = 2'd0,
		MODE_SMALLEST_OWNED = 2'd1,
		MODE_FIRST_ABOVE    = 2'd2
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SEARCH_MODE = 2'd0,
		CFG_OWNER_ID    = 2'd1,
		CFG_MIN_LENGTH  = 2'd2
	} cfg_index_t;

endpackage

`default_nettype wire

// File: sv/section_run_finder_core.sv
// ----------------------------------------------------------------------------
// section_run_finder_core
// Streams section owners and picks one run of matching sections per scan.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one section per beat (owner, number), tlast on the final
//   section of a scan. m_axis carries one result beat per scan (start,
//   length) with tuser set when a run was found. cfg writes search_mode,
//   owner_id or min_length by index; write only between scans.
// The tlast beat enters the input register when accepted, and the result
//   register loads from it as it leaves, unless a stalled result holds it.
// Throughput: one section per cycle while no tlast beat waits on a stalled
//   result; compare and best update are combinational on the input register.
// Reset clears the run and best trackers, config registers and stage valids.
// If m_axis stalls with a result held, a following tlast beat waits in the
//   input register and s_axis_tready drops; beats without tlast keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module section_run_finder_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// s_axis_tdata: section_owner[8:0], section_number[32:9], zero pad
	input  wire logic [srf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic                             s_axis_tlast,
	// m_axis_tdata: region_start[23:0], region_length[34:24], zero pad
	output logic [srf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// m_axis_tuser: region_found
	output logic                                  m_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [srf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [srf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import srf_pkg::*;

	`include "assert_macros.svh"

	// first run of an owner is taken only if shorter than POOL_SECTIONS + 1
	localparam logic [LENGTH_W:0] POOL_LIMIT = (LENGTH_W+1)'(
		(POOL_SECTIONS > int'(LENGTH_MAX)) ? int'(LENGTH_MAX) + 1 : POOL_SECTIONS + 1);

	// configuration
	logic [MODE_W-1:0]         search_mode_q;
	logic [OWNER_W-1:0]        owner_id_q;
	logic [LENGTH_W-1:0]       min_length_q;

	// input stage
	logic                      valid_s1;
	logic [OWNER_W-1:0]        owner_s1;
	logic [NUMBER_W-1:0]       number_s1;
	logic                      last_s1;

	// run trackers
	logic                      run_active_q;
	logic [NUMBER_W-1:0]       run_start_q;
	logic [LENGTH_W-1:0]       run_length_q;
	logic [NUMBER_W-1:0]       best_start_q;
	logic [LENGTH_W-1:0]       best_length_q;
	logic                      best_valid_q;

	// result stage
	logic                      valid_s2;
	logic [NUMBER_W-1:0]       start_s2;
	logic [LENGTH_W-1:0]       length_s2;
	logic                      found_s2;

	logic                      stall;
	logic                      advance;
	logic                      match;
	logic                      close_run;
	logic                      judge_en;
	logic                      take;
	logic [LENGTH_W-1:0]       run_len_inc;
	logic [NUMBER_W-1:0]       cand_start;
	logic [LENGTH_W-1:0]       cand_length;
	logic [NUMBER_W-1:0]       nb_start;
	logic [LENGTH_W-1:0]       nb_length;
	logic                      nb_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_mode_q <= '0;
			owner_id_q    <= '0;
			min_length_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SEARCH_MODE: search_mode_q <= cfg_data[MODE_W-1:0];
				CFG_OWNER_ID:    owner_id_q    <= cfg_data[OWNER_W-1:0];
				CFG_MIN_LENGTH:  min_length_q  <= cfg_data[LENGTH_W-1:0];
				default:         ;
			endcase
		end
	end

	// hold a tlast beat while the result register is full and stalled
	assign stall         = valid_s1 && last_s1 && valid_s2 && !m_axis_tready;
	assign advance       = valid_s1 && !stall;
	assign s_axis_tready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			owner_s1  <= s_axis_tdata[OWNER_W-1:0];
			number_s1 <= s_axis_tdata[IN_FIELDS_W-1:OWNER_W];
			last_s1   <= s_axis_tlast;
		end
	end

	always_comb begin
		case (search_mode_q)
			MODE_LARGEST_FREE,
			MODE_FIRST_ABOVE:    match = owner_s1[OWNER_W-1];
			MODE_SMALLEST_OWNED: match = (owner_s1 == owner_id_q);
			default:             match = 1'b0;
		endcase
	end

	// At most one run is judged per beat: the open run when this section
	// breaks it, or the run that this section extends or starts on the tlast beat.
	always_comb begin
		run_len_inc = (run_length_q == LENGTH_MAX) ? run_length_q
			: run_length_q + LENGTH_W'(1);
		close_run   = run_active_q && !match;
		judge_en    = close_run || (last_s1 && match);
		if (close_run) begin
			cand_start  = run_start_q;
			cand_length = run_length_q;
		end else if (run_active_q) begin
			cand_start  = run_start_q;
			cand_length = run_len_inc;
		end else begin
			cand_start  = number_s1;
			cand_length = LENGTH_W'(1);
		end

		case (search_mode_q)
			MODE_LARGEST_FREE:   take = (cand_length > best_length_q);
			MODE_SMALLEST_OWNED: take = best_valid_q ? (cand_length < best_length_q)
				: ({1'b0, cand_length} < POOL_LIMIT);
			MODE_FIRST_ABOVE:    take = !best_valid_q && (cand_length > min_length_q);
			default:             take = 1'b0;
		endcase

		if (judge_en && take) begin
			nb_start  = cand_start;
			nb_length = cand_length;
			nb_valid  = 1'b1;
		end else begin
			nb_start  = best_start_q;
			nb_length = best_length_q;
			nb_valid  = best_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_active_q  <= 1'b0;
			run_start_q   <= '0;
			run_length_q  <= '0;
			best_start_q  <= '0;
			best_length_q <= '0;
			best_valid_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				// scan done: clear everything for the next one
				run_active_q  <= 1'b0;
				run_start_q   <= '0;
				run_length_q  <= '0;
				best_start_q  <= '0;
				best_length_q <= '0;
				best_valid_q  <= 1'b0;
			end else begin
				best_start_q  <= nb_start;
				best_length_q <= nb_length;
				best_valid_q  <= nb_valid;
				if (!match) begin
					run_active_q <= 1'b0;
					run_start_q  <= '0;
					run_length_q <= '0;
				end else if (run_active_q) begin
					run_length_q <= run_len_inc;
				end else begin
					run_active_q <= 1'b1;
					run_start_q  <= number_s1;
					run_length_q <= LENGTH_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			start_s2  <= nb_valid ? nb_start : '0;
			length_s2 <= nb_valid ? nb_length : '0;
			found_s2  <= nb_valid;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = found_s2;
	assign m_axis_tdata  = {(OUT_TDATA_W-OUT_FIELDS_W)'(0), length_s2, start_s2};

	`ASSERT_ALWAYS(a_run_len_zero_idle, run_active_q || (run_length_q == '0), "idle run has a length")
	`ASSERT_ALWAYS(a_run_len_nonzero, !run_active_q || (run_length_q != '0), "open run has zero length")
	`ASSERT_ALWAYS(a_best_len_invalid, best_valid_q || (best_length_q == '0), "best length without a best run")
	`ASSERT_ALWAYS(a_result_none_zero, !valid_s2 || found_s2 || ((start_s2 == '0) && (length_s2 == '0)), "empty result carries data")
	`ASSERT_NEXT(a_last_beat_held, stall, valid_s1 && last_s1, "stalled tlast beat dropped")

endmodule

`default_nettype wire
